// ===== rtl/core/least_squares_cell_gradient_top_macros.svh =====
// Assertion shorthands for the cell gradient block.
// Each one samples on the rising edge of clk and is switched off while rst is high.
`ifndef LEAST_SQUARES_CELL_GRADIENT_TOP_MACROS_SVH
`define LEAST_SQUARES_CELL_GRADIENT_TOP_MACROS_SVH

// condition in the same cycle
`define LSCG_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// condition in the next cycle
`define LSCG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/lscg_pkg.sv =====
`timescale 1ns / 1ps

package lscg_pkg;

  // value width; the gradient clamps at the narrower of this and the port width
  localparam int VALUE_WIDTH = 32;
  localparam int GRAD_W      = 32;
  localparam int SAT_W_RAW   = (VALUE_WIDTH < GRAD_W) ? VALUE_WIDTH : GRAD_W;
  localparam int SAT_W       = (SAT_W_RAW < 2) ? 2 : SAT_W_RAW;

  // field and datapath widths
  localparam int COEF_W     = 32;
  localparam int VAL_W      = 32;
  localparam int MUL_W      = 33;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int SUM_W      = 48;
  localparam int ACC_W      = 58;
  localparam int FRAC_SHIFT = 24;
  localparam int SHIFTED_W  = PROD_W - FRAC_SHIFT;

  // clamp limits in accumulator width
  localparam logic signed [ACC_W-1:0] ACC_HI =
    (ACC_W'(1) <<< (SAT_W - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] ACC_LO = -ACC_HI - ACC_W'(1);

  // configuration
  localparam int PADDR_W = 2;
  localparam int PDATA_W = 32;
  localparam int DIM_W   = 2;
  localparam logic [PADDR_W-1:0] REG_DIMENSION_ADDR = PADDR_W'(0);
  localparam logic [DIM_W-1:0]   DIM_RESET = 2'd3;
  localparam logic [DIM_W-1:0]   DIM_2D    = 2'd2;

  // item codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_FACE = 1'b1;
  localparam logic [1:0] ROW_NONE = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FACE,
    S_FDRAIN,
    S_CLOSE,
    S_CDRAIN,
    S_FIN
  } state_t;

  // what the registered product is for
  typedef enum logic [1:0] {
    TAG_FACE,
    TAG_LO,
    TAG_HI
  } tag_kind_t;

  typedef struct packed {
    tag_kind_t   kind;
    logic [1:0]  idx;
    logic        row_end;
  } mul_tag_t;

endpackage

// ===== rtl/core/least_squares_cell_gradient_top.sv =====
`timescale 1ns / 1ps

// Weighted least-squares gradient of one cell variable, Q16.16 values with
// Q8.24 weights and matrix. All products go through one 33x33 signed multiplier
// with a registered output, so that multiplier sets how soon the next item can
// be taken. A matrix row load is taken in the idle state and leaves the input
// ready for the next item, as does a boundary face that is not the last face.
// A face with a neighbour issues D products, where D is 2 in 2D mode and 3
// otherwise, and then drains the multiplier. The last face of a cell then runs
// the closing matrix-vector product. Each of its D*D terms needs two passes
// through the multiplier, one for the low 24 and one for the high 24 bits of the 48-bit sum.
// The result is held in an output register, so the next cell may start while
// it waits to be taken; a closing product that finds that register still full
// holds the input until it is taken. No clearing pass follows reset.
module least_squares_cell_gradient_top (
  input  logic                                clk,
  input  logic                                rst,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lscg_pkg::PADDR_W-1:0]        paddr,
  input  logic [lscg_pkg::PDATA_W-1:0]        pwdata,
  output logic [lscg_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready,
  // input items
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                op,
  input  logic [1:0]                          row_index,
  input  logic signed [lscg_pkg::COEF_W-1:0]  coef_x,
  input  logic signed [lscg_pkg::COEF_W-1:0]  coef_y,
  input  logic signed [lscg_pkg::COEF_W-1:0]  coef_z,
  input  logic signed [lscg_pkg::VAL_W-1:0]   center_value,
  input  logic signed [lscg_pkg::VAL_W-1:0]   neighbor_value,
  input  logic                                neighbor_valid,
  input  logic                                last_face,
  // results
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [lscg_pkg::GRAD_W-1:0]  grad_x,
  output logic signed [lscg_pkg::GRAD_W-1:0]  grad_y,
  output logic signed [lscg_pkg::GRAD_W-1:0]  grad_z,
  output logic                                saturated
);
  import lscg_pkg::*;

  state_t state, state_next;

  logic [DIM_W-1:0]               dimension;
  logic signed [COEF_W-1:0]       matrix [3][3];
  logic signed [SUM_W-1:0]        ws [3];
  logic signed [COEF_W-1:0]       coef_q [3];
  logic signed [MUL_W-1:0]        diff_q;
  logic                           last_q;
  logic [1:0]                     d_cnt;
  logic [1:0]                     row_cnt;
  logic [1:0]                     col_cnt;
  logic                           half_q;
  logic signed [ACC_W-1:0]        acc;
  logic signed [GRAD_W-1:0]       grad_w [3];
  logic                           sat_w;

  logic                           in_fire;
  logic                           cfg_write;
  logic                           out_free;
  logic [1:0]                     last_idx;
  logic                           issue;
  logic signed [MUL_W-1:0]        mul_a;
  logic signed [MUL_W-1:0]        mul_b;
  mul_tag_t                       tag_in;
  logic signed [PROD_W-1:0]       prod;
  mul_tag_t                       ptag;
  logic                           prod_valid;
  logic signed [SUM_W-1:0]        term_face;
  logic signed [ACC_W-1:0]        contrib;
  logic signed [ACC_W-1:0]        acc_sum;
  logic signed [GRAD_W-1:0]       clamped;
  logic                           clamp_hit;
  logic signed [MUL_W-1:0]        diff_in;

  assign in_fire   = in_valid && in_ready;
  assign cfg_write = psel && penable && pwrite && pready;
  assign out_free  = !out_valid || out_ready;
  assign last_idx  = (dimension == DIM_2D) ? 2'd1 : 2'd2;
  assign diff_in   = $signed({neighbor_value[VAL_W-1], neighbor_value})
                   - $signed({center_value[VAL_W-1], center_value});

  // configuration register
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dimension <= DIM_RESET;
    end else if (cfg_write && paddr == REG_DIMENSION_ADDR) begin
      dimension <= pwdata[DIM_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == REG_DIMENSION_ADDR) begin
      prdata = PDATA_W'(dimension);
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer: next state and multiplier operands
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    issue      = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    tag_in     = '{kind: TAG_FACE, idx: 2'd0, row_end: 1'b0};
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && op == OP_FACE) begin
          if (neighbor_valid) begin
            state_next = S_FACE;
          end else if (last_face) begin
            state_next = S_CLOSE;
          end
        end
      end
      S_FACE: begin
        issue  = 1'b1;
        mul_a  = {coef_q[d_cnt][COEF_W-1], coef_q[d_cnt]};
        mul_b  = diff_q;
        tag_in = '{kind: TAG_FACE, idx: d_cnt, row_end: 1'b0};
        if (d_cnt == last_idx) begin
          state_next = S_FDRAIN;
        end
      end
      S_FDRAIN: begin
        state_next = last_q ? S_CLOSE : S_IDLE;
      end
      S_CLOSE: begin
        issue = 1'b1;
        mul_a = {matrix[row_cnt][col_cnt][COEF_W-1], matrix[row_cnt][col_cnt]};
        if (half_q) begin
          // high part of the sum, signed
          mul_b = {{(MUL_W-SUM_W+FRAC_SHIFT){ws[col_cnt][SUM_W-1]}},
                   ws[col_cnt][SUM_W-1:FRAC_SHIFT]};
        end else begin
          // low part of the sum, unsigned
          mul_b = {{(MUL_W-FRAC_SHIFT){1'b0}}, ws[col_cnt][FRAC_SHIFT-1:0]};
        end
        tag_in = '{kind: half_q ? TAG_HI : TAG_LO, idx: row_cnt,
                   row_end: half_q && (col_cnt == last_idx)};
        if (half_q && col_cnt == last_idx && row_cnt == last_idx) begin
          state_next = S_CDRAIN;
        end
      end
      S_CDRAIN: begin
        state_next = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // step counters
  always_ff @(posedge clk) begin
    if (rst) begin
      d_cnt   <= 2'd0;
      row_cnt <= 2'd0;
      col_cnt <= 2'd0;
      half_q  <= 1'b0;
    end else begin
      if (state == S_FACE) begin
        d_cnt <= d_cnt + 2'd1;
      end else begin
        d_cnt <= 2'd0;
      end
      if (state == S_CLOSE) begin
        half_q <= !half_q;
        if (half_q) begin
          if (col_cnt == last_idx) begin
            col_cnt <= 2'd0;
            row_cnt <= row_cnt + 2'd1;
          end else begin
            col_cnt <= col_cnt + 2'd1;
          end
        end
      end else begin
        row_cnt <= 2'd0;
        col_cnt <= 2'd0;
        half_q  <= 1'b0;
      end
    end
  end

  // face operands
  always_ff @(posedge clk) begin
    if (in_fire && op == OP_FACE) begin
      coef_q[0] <= coef_x;
      coef_q[1] <= coef_y;
      coef_q[2] <= coef_z;
      diff_q    <= diff_in;
      last_q    <= last_face;
    end
  end

  // matrix rows
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          matrix[r][c] <= '0;
        end
      end
    end else if (in_fire && op == OP_LOAD && row_index != ROW_NONE) begin
      matrix[row_index][0] <= coef_x;
      matrix[row_index][1] <= coef_y;
      matrix[row_index][2] <= coef_z;
    end
  end

  lscg_mul u_mul (
    .clk        (clk),
    .rst        (rst),
    .issue      (issue),
    .a          (mul_a),
    .b          (mul_b),
    .tag_in     (tag_in),
    .prod       (prod),
    .tag_out    (ptag),
    .prod_valid (prod_valid)
  );

  // product scaling and clamp
  always_comb begin
    term_face = {{(SUM_W-SHIFTED_W){prod[PROD_W-1]}}, prod[PROD_W-1:FRAC_SHIFT]};
    case (ptag.kind)
      TAG_LO:  contrib = {{(ACC_W-SHIFTED_W){prod[PROD_W-1]}},
                          prod[PROD_W-1:FRAC_SHIFT]};
      TAG_HI:  contrib = prod[ACC_W-1:0];
      default: contrib = '0;
    endcase
    acc_sum = acc + contrib;
    if (acc_sum > ACC_HI) begin
      clamped   = ACC_HI[GRAD_W-1:0];
      clamp_hit = 1'b1;
    end else if (acc_sum < ACC_LO) begin
      clamped   = ACC_LO[GRAD_W-1:0];
      clamp_hit = 1'b1;
    end else begin
      clamped   = acc_sum[GRAD_W-1:0];
      clamp_hit = 1'b0;
    end
  end

  // face sums: accumulate, clear once the result is taken over
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        ws[i] <= '0;
      end
    end else if (state == S_FIN && out_free) begin
      for (int i = 0; i < 3; i++) begin
        ws[i] <= '0;
      end
    end else if (prod_valid && ptag.kind == TAG_FACE) begin
      ws[ptag.idx] <= ws[ptag.idx] + term_face;
    end
  end

  // row accumulator and working gradient
  always_ff @(posedge clk) begin
    if (rst) begin
      acc   <= '0;
      sat_w <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        grad_w[i] <= '0;
      end
    end else begin
      if (state == S_CLOSE && row_cnt == 2'd0 && col_cnt == 2'd0 && !half_q) begin
        sat_w <= 1'b0;
        for (int i = 0; i < 3; i++) begin
          grad_w[i] <= '0;
        end
      end
      if (prod_valid && ptag.kind != TAG_FACE) begin
        if (ptag.row_end) begin
          acc               <= '0;
          grad_w[ptag.idx]  <= clamped;
          sat_w             <= sat_w | clamp_hit;
        end else begin
          acc <= acc_sum;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && out_free) begin
      grad_x    <= grad_w[0];
      grad_y    <= grad_w[1];
      grad_z    <= grad_w[2];
      saturated <= sat_w;
    end
  end

endmodule

// ===== rtl/core/lscg_mul.sv =====
`timescale 1ns / 1ps

// Shared signed multiplier with a registered product and its routing tag.
module lscg_mul (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                issue,
  input  logic signed [lscg_pkg::MUL_W-1:0]   a,
  input  logic signed [lscg_pkg::MUL_W-1:0]   b,
  input  lscg_pkg::mul_tag_t                  tag_in,
  output logic signed [lscg_pkg::PROD_W-1:0]  prod,
  output lscg_pkg::mul_tag_t                  tag_out,
  output logic                                prod_valid
);
  import lscg_pkg::*;

  // product valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= issue;
    end
  end

  // product and tag
  always_ff @(posedge clk) begin
    if (issue) begin
      prod    <= a * b;
      tag_out <= tag_in;
    end
  end

endmodule

// ===== rtl/core/lscg_port_chk.sv =====
`timescale 1ns / 1ps
`include "least_squares_cell_gradient_top_macros.svh"

// Port-level checks on the cell gradient block.
module lscg_port_chk (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               op,
  input logic                               neighbor_valid,
  input logic                               last_face,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [lscg_pkg::GRAD_W-1:0] grad_x,
  input logic signed [lscg_pkg::GRAD_W-1:0] grad_y,
  input logic signed [lscg_pkg::GRAD_W-1:0] grad_z,
  input logic                               saturated
);
  import lscg_pkg::*;

  // a waiting result holds
  `LSCG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(grad_x) && $stable(grad_y) && $stable(grad_z) && $stable(saturated), "result changed while stalled")

  // a face with a neighbour occupies the multiplier
  `LSCG_ASSERT_NEXT(a_face_busy, in_valid && in_ready && op == OP_FACE && neighbor_valid, !in_ready, "ready during face multiply")

  // a matrix row load completes at once
  `LSCG_ASSERT_NEXT(a_load_quick, in_valid && in_ready && op == OP_LOAD, in_ready, "not ready after row load")

  // an inner boundary face adds nothing and needs no time
  `LSCG_ASSERT_NEXT(a_bnd_quick, in_valid && in_ready && op == OP_FACE && !neighbor_valid && !last_face, in_ready, "not ready after boundary face")

endmodule

bind least_squares_cell_gradient_top lscg_port_chk u_port_chk (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .op             (op),
  .neighbor_valid (neighbor_valid),
  .last_face      (last_face),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .grad_x         (grad_x),
  .grad_y         (grad_y),
  .grad_z         (grad_z),
  .saturated      (saturated)
);
